// ===== hdl/assert_macros.svh =====
// Assertion macros used by the sorted timer queue top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, held off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication whose consequent is due in the next cycle.
`define ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

// ===== hdl/stq_pkg.sv =====
// Types, codes and sizes of the sorted timer queue.
package stq_pkg;

    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DL_W    = 32;
    localparam int ID_W    = 32;
    localparam int TAG_W   = 32;
    localparam int OCC_W   = 7;

    typedef enum logic [1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_CANCEL   = 2'd1,
        CMD_FIRE     = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Per-cycle operation broadcast to every cell.
    typedef struct packed {
        logic schedule;
        logic cancel;
        logic fire;
    } cell_op_t;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  new_id;
        logic [ID_W-1:0]  fired_id;
        logic [TAG_W-1:0] fired_tag;
        logic [DL_W-1:0]  fired_deadline;
        logic [OCC_W-1:0] occupancy;
    } result_t;

endpackage

// ===== hdl/stq_in_if.sv =====
// Command channel of the sorted timer queue.
interface stq_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic [stq_pkg::DL_W-1:0]  deadline;
    logic [stq_pkg::ID_W-1:0]  cancel_id;
    logic [stq_pkg::TAG_W-1:0] user_tag;

    modport source (output valid, cmd, deadline, cancel_id, user_tag, input ready);
    modport sink (input valid, cmd, deadline, cancel_id, user_tag, output ready);
endinterface

// ===== hdl/stq_out_if.sv =====
// Result channel of the sorted timer queue.
interface stq_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [stq_pkg::ID_W-1:0]  new_id;
    logic [stq_pkg::ID_W-1:0]  fired_id;
    logic [stq_pkg::TAG_W-1:0] fired_tag;
    logic [stq_pkg::DL_W-1:0]  fired_deadline;
    logic [stq_pkg::OCC_W-1:0] occupancy;

    modport source (output valid, status, new_id, fired_id, fired_tag, fired_deadline,
                    occupancy, input ready);
    modport sink (input valid, status, new_id, fired_id, fired_tag, fired_deadline,
                  occupancy, output ready);
endinterface

// ===== hdl/stq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
module stq_cell (
    input  logic                      clk,
    input  stq_pkg::cell_op_t         op,
    input  logic                      occupied,
    input  logic [stq_pkg::DL_W-1:0]  key_deadline,
    input  logic [stq_pkg::ID_W-1:0]  key_id,
    input  stq_pkg::entry_t           new_entry,
    input  stq_pkg::entry_t           left_entry,
    input  stq_pkg::entry_t           right_entry,
    input  logic                      left_ge,
    input  logic                      match_in,
    output stq_pkg::entry_t           entry,
    output logic                      ge,
    output logic                      match_out
);

    stq_pkg::entry_t entry_reg;
    stq_pkg::entry_t entry_next;
    logic            hit;

    always_comb
    begin
        // An empty slot counts as later than any deadline.
        ge        = !occupied || (entry_reg.deadline >= key_deadline);
        hit       = occupied && (entry_reg.deadline == key_deadline) && (entry_reg.id == key_id);
        match_out = match_in || hit;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (op.schedule)
        begin
            // Slots after the insertion point shift right by one.
            if (left_ge)
                entry_next = left_entry;
            else if (ge)
                entry_next = new_entry;
        end
        if (op.cancel && match_out)
            entry_next = right_entry;
        if (op.fire)
            entry_next = right_entry;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== hdl/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: cell chain, counters and result register.
//
// Holds up to DEPTH timers in a chain of cells kept sorted by ascending
// deadline; a schedule goes in front of any equal deadline. Every command
// (schedule, cancel, fire) is applied to the whole chain in the cycle it is
// accepted, and its result word appears in the output register on the next
// cycle, so the block takes one word per cycle while results are taken
// promptly; a stalled result holds the command channel until it is taken.
// The cycle time is set by the deadline compare in each cell and by the
// cancel match that ripples through all DEPTH cells. No clearing pass is
// needed after reset: the fill count alone marks which cells hold timers.
`include "assert_macros.svh"

module sorted_timer_queue (
    input  logic          clk,
    input  logic          rst_n,
    stq_in_if.sink        req,
    stq_out_if.source     rsp
);

    localparam int DEPTH = stq_pkg::DEPTH;
    localparam int CNT_W = stq_pkg::CNT_W;

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [stq_pkg::ID_W-1:0]    id_reg;
    logic [stq_pkg::ID_W-1:0]    id_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    stq_pkg::result_t            out_reg;
    stq_pkg::result_t            out_next;

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        found;
    stq_pkg::cmd_t               cmd;
    stq_pkg::cell_op_t           op;
    stq_pkg::entry_t             new_entry;

    stq_pkg::entry_t             ent       [DEPTH];
    logic                        ge        [DEPTH];
    logic                        match_out [DEPTH];
    logic                        occupied  [DEPTH];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign cmd       = stq_pkg::cmd_t'(req.cmd);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign found     = match_out[DEPTH-1];

    assign new_entry.deadline = req.deadline;
    assign new_entry.id       = id_reg;
    assign new_entry.tag      = req.user_tag;

    assign op.schedule = accept && (cmd == stq_pkg::CMD_SCHEDULE) && !full;
    assign op.cancel   = accept && (cmd == stq_pkg::CMD_CANCEL);
    assign op.fire     = accept && (cmd == stq_pkg::CMD_FIRE) && !empty;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        stq_pkg::entry_t left_entry;
        stq_pkg::entry_t right_entry;
        logic            left_ge;
        logic            match_in;

        assign occupied[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_entry = new_entry;
            assign left_ge    = 1'b0;
            assign match_in   = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = ent[i-1];
            assign left_ge    = ge[i-1];
            assign match_in   = match_out[i-1];
        end

        // The last cell takes a don't-care word when the chain shifts left.
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = new_entry;
        end
        else
        begin : g_mid
            assign right_entry = ent[i+1];
        end

        stq_cell u_cell (
            .clk          (clk),
            .op           (op),
            .occupied     (occupied[i]),
            .key_deadline (req.deadline),
            .key_id       (req.cancel_id),
            .new_entry    (new_entry),
            .left_entry   (left_entry),
            .right_entry  (right_entry),
            .left_ge      (left_ge),
            .match_in     (match_in),
            .entry        (ent[i]),
            .ge           (ge[i]),
            .match_out    (match_out[i])
        );
    end

    always_comb
    begin
        count_next              = count_reg;
        id_next                 = id_reg;
        out_next.status         = stq_pkg::ST_OK;
        out_next.new_id         = '0;
        out_next.fired_id       = '0;
        out_next.fired_tag      = '0;
        out_next.fired_deadline = '0;
        if (accept)
        begin
            case (cmd)
                stq_pkg::CMD_SCHEDULE:
                begin
                    if (full)
                        out_next.status = stq_pkg::ST_FULL;
                    else
                    begin
                        out_next.new_id = id_reg;
                        id_next         = id_reg + 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                end
                stq_pkg::CMD_CANCEL:
                begin
                    if (found)
                        count_next = count_reg - 1'b1;
                    else
                        out_next.status = stq_pkg::ST_NOT_FOUND;
                end
                stq_pkg::CMD_FIRE:
                begin
                    if (empty)
                        out_next.status = stq_pkg::ST_EMPTY;
                    else
                    begin
                        out_next.fired_id       = ent[0].id;
                        out_next.fired_tag      = ent[0].tag;
                        out_next.fired_deadline = ent[0].deadline;
                        count_next              = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        out_next.occupancy = stq_pkg::OCC_W'(count_next);
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            id_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            id_reg        <= id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.new_id         = out_reg.new_id;
    assign rsp.fired_id       = out_reg.fired_id;
    assign rsp.fired_tag      = out_reg.fired_tag;
    assign rsp.fired_deadline = out_reg.fired_deadline;
    assign rsp.occupancy      = out_reg.occupancy;

    `ASSERT_CLK(a_count_bound, count_reg <= CNT_W'(DEPTH), "fill count beyond depth")
    `ASSERT_NEXT(a_id_advance, op.schedule, id_reg == $past(id_reg) + 1'b1, "id not advanced")
    `ASSERT_CLK(a_stall_holds, (out_valid_reg && !rsp.ready) |-> !req.ready, "word taken on stall")
    `ASSERT_CLK(a_head_sorted, (count_reg >= CNT_W'(2)) |-> (ent[0].deadline <= ent[1].deadline), "head out of order")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of the sorted timer queue: directed list, random phases, live predictor.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        stq_pkg::cmd_t    cmd;
        logic [31:0]      deadline;
        logic [31:0]      cancel_id;
        logic [31:0]      user_tag;
        bit               known;
        stq_pkg::result_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    stq_in_if  req_if ();
    stq_out_if rsp_if ();

    sorted_timer_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the timer list, kept sorted as the block keeps it
    stq_pkg::entry_t  shadow_timers[$];
    logic [31:0]      shadow_next_id;
    stq_pkg::result_t pending_results[$];
    int               fail_count;
    bit               gaps_on;
    bit               hold_request;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic stq_pkg::result_t predict_outcome(stq_pkg::cmd_t c, logic [31:0] dl,
                                                         logic [31:0] cid, logic [31:0] tag);
        stq_pkg::result_t r;
        stq_pkg::entry_t  e;
        int               pos;
        bit               hit;
        r = '0;
        r.status = stq_pkg::ST_OK;
        case (c)
            stq_pkg::CMD_SCHEDULE:
            begin
                if (shadow_timers.size() >= stq_pkg::DEPTH)
                begin
                    r.status = stq_pkg::ST_FULL;
                end
                else
                begin
                    // go in front of every equal or later deadline
                    pos = 0;
                    while (pos < shadow_timers.size() && shadow_timers[pos].deadline < dl)
                        pos++;
                    e.deadline = dl;
                    e.id = shadow_next_id;
                    e.tag = tag;
                    shadow_timers.insert(pos, e);
                    r.new_id = shadow_next_id;
                    shadow_next_id = shadow_next_id + 32'd1;
                end
            end
            stq_pkg::CMD_CANCEL:
            begin
                hit = 1'b0;
                for (pos = 0; pos < shadow_timers.size(); pos++)
                begin
                    if (shadow_timers[pos].deadline == dl && shadow_timers[pos].id == cid)
                    begin
                        shadow_timers.delete(pos);
                        hit = 1'b1;
                        break;
                    end
                end
                if (!hit)
                    r.status = stq_pkg::ST_NOT_FOUND;
            end
            stq_pkg::CMD_FIRE:
            begin
                if (shadow_timers.size() == 0)
                begin
                    r.status = stq_pkg::ST_EMPTY;
                end
                else
                begin
                    e = shadow_timers.pop_front();
                    r.fired_id = e.id;
                    r.fired_tag = e.tag;
                    r.fired_deadline = e.deadline;
                end
            end
            default: ;
        endcase
        r.occupancy = stq_pkg::OCC_W'(shadow_timers.size());
        return r;
    endfunction

    function automatic stim_row_t stim_row(stq_pkg::cmd_t c, logic [31:0] dl,
                                           logic [31:0] cid, logic [31:0] tag, int known,
                                           stq_pkg::status_t st, logic [31:0] nid,
                                           logic [31:0] fid, logic [31:0] ftag,
                                           logic [31:0] fdl, int occ);
        stim_row_t row;
        row.cmd = c;
        row.deadline = dl;
        row.cancel_id = cid;
        row.user_tag = tag;
        row.known = (known != 0);
        row.want.status = st;
        row.want.new_id = nid;
        row.want.fired_id = fid;
        row.want.fired_tag = ftag;
        row.want.fired_deadline = fdl;
        row.want.occupancy = stq_pkg::OCC_W'(occ);
        return row;
    endfunction

    // Favour deadlines that collide, so equal-deadline ordering gets exercised
    function automatic logic [31:0] random_deadline();
        logic [31:0] dl;
        case ($urandom_range(0, 7))
            0: dl = 32'h0000_0000;
            1: dl = 32'hFFFF_FFFF;
            2, 3: dl = $urandom_range(0, 15);
            4:
            begin
                if (shadow_timers.size() != 0)
                    dl = shadow_timers[$urandom_range(0, shadow_timers.size() - 1)].deadline;
                else
                    dl = $urandom;
            end
            default: dl = $urandom;
        endcase
        return dl;
    endfunction

    function automatic stim_row_t random_row(int w_sched, int w_cancel, int w_fire);
        stim_row_t       row;
        stq_pkg::entry_t e;
        int              pick;
        logic [31:0]     flip;
        pick = $urandom_range(0, 99);
        row = stim_row(stq_pkg::CMD_NOP, $urandom, $urandom, $urandom, 0, stq_pkg::ST_OK,
                       0, 0, 0, 0, 0);
        if (pick < w_sched)
        begin
            row.cmd = stq_pkg::CMD_SCHEDULE;
            row.deadline = random_deadline();
        end
        else if (pick < w_sched + w_cancel)
        begin
            row.cmd = stq_pkg::CMD_CANCEL;
            if (shadow_timers.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                // aim at a held timer, now and then off by one bit
                e = shadow_timers[$urandom_range(0, shadow_timers.size() - 1)];
                row.deadline = e.deadline;
                row.cancel_id = e.id;
                if ($urandom_range(0, 5) == 0)
                begin
                    flip = 32'd1 << $urandom_range(0, 31);
                    if ($urandom_range(0, 1) == 0)
                        row.deadline = row.deadline ^ flip;
                    else
                        row.cancel_id = row.cancel_id ^ flip;
                end
            end
            else
            begin
                row.deadline = random_deadline();
                if ($urandom_range(0, 1) == 0)
                    row.cancel_id = shadow_next_id - $urandom_range(0, 80);
            end
        end
        else if (pick < w_sched + w_cancel + w_fire)
        begin
            row.cmd = stq_pkg::CMD_FIRE;
        end
        return row;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    task automatic check_result();
        stq_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected result word: expected none, actual status %0d occupancy %0d",
                     $time, rsp_if.status, rsp_if.occupancy);
            return;
        end
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_if.status));
        check_field("new_id", want.new_id, rsp_if.new_id);
        check_field("fired_id", want.fired_id, rsp_if.fired_id);
        check_field("fired_tag", want.fired_tag, rsp_if.fired_tag);
        check_field("fired_deadline", want.fired_deadline, rsp_if.fired_deadline);
        check_field("occupancy", 32'(want.occupancy), 32'(rsp_if.occupancy));
    endtask

    task automatic offer(stim_row_t row);
        stq_pkg::result_t predicted;
        req_if.valid <= 1'b1;
        req_if.cmd <= row.cmd;
        req_if.deadline <= row.deadline;
        req_if.cancel_id <= row.cancel_id;
        req_if.user_tag <= row.user_tag;
        do
            @(posedge clk);
        while (!req_if.ready);
        predicted = predict_outcome(row.cmd, row.deadline, row.cancel_id, row.user_tag);
        pending_results.push_back(row.known ? row.want : predicted);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Count only words that do something; no-op words ride along
    task automatic run_random(int count, int w_sched, int w_cancel, int w_fire);
        stim_row_t row;
        int        done;
        done = 0;
        while (done < count)
        begin
            row = random_row(w_sched, w_cancel, w_fire);
            offer(row);
            if (row.cmd != stq_pkg::CMD_NOP)
                done++;
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        bit next_ready;
        stall_left = 0;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                check_result();
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
            end
            rsp_if.ready <= next_ready;
        end
    end

    // Command side
    initial
    begin
        stim_row_t stim_list[$];
        fail_count = 0;
        gaps_on = 1'b1;
        hold_request = 1'b0;
        shadow_next_id = 32'd0;
        req_if.valid = 1'b0;
        req_if.cmd = stq_pkg::CMD_NOP;
        req_if.deadline = '0;
        req_if.cancel_id = '0;
        req_if.user_tag = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stim_list.push_back(stim_row(stq_pkg::CMD_FIRE, 0, 0, 0, 1, stq_pkg::ST_EMPTY,
                                     0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_CANCEL, 0, 0, 0, 1, stq_pkg::ST_NOT_FOUND,
                                     0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 1, stq_pkg::ST_OK, 0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_SCHEDULE, 0, 0, 0, 1, stq_pkg::ST_OK,
                                     0, 0, 0, 0, 1));
        stim_list.push_back(stim_row(stq_pkg::CMD_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 1, stq_pkg::ST_OK, 1, 0, 0, 0, 2));
        stim_list.push_back(stim_row(stq_pkg::CMD_SCHEDULE, 0, 0, 32'h5A5A_5A5A, 1,
                                     stq_pkg::ST_OK, 2, 0, 0, 0, 3));
        stim_list.push_back(stim_row(stq_pkg::CMD_SCHEDULE, 32'h8000_0000, 0, 32'hA5A5_A5A5,
                                     1, stq_pkg::ST_OK, 3, 0, 0, 0, 4));
        // newest of two equal deadlines sits at the head
        stim_list.push_back(stim_row(stq_pkg::CMD_FIRE, 0, 0, 0, 1, stq_pkg::ST_OK,
                                     0, 2, 32'h5A5A_5A5A, 0, 3));
        stim_list.push_back(stim_row(stq_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 0, 0, 1,
                                     stq_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 3));
        stim_list.push_back(stim_row(stq_pkg::CMD_CANCEL, 0, 1, 0, 1, stq_pkg::ST_NOT_FOUND,
                                     0, 0, 0, 0, 3));
        stim_list.push_back(stim_row(stq_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 1, 0, 1,
                                     stq_pkg::ST_OK, 0, 0, 0, 0, 2));
        stim_list.push_back(stim_row(stq_pkg::CMD_SCHEDULE, 32'h8000_0000, 0, 32'h1, 0,
                                     stq_pkg::ST_OK, 0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_FIRE, 0, 0, 0, 1, stq_pkg::ST_OK,
                                     0, 0, 0, 0, 2));
        stim_list.push_back(stim_row(stq_pkg::CMD_FIRE, 0, 0, 0, 0, stq_pkg::ST_OK,
                                     0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_CANCEL, 32'h8000_0000, 3, 0, 1,
                                     stq_pkg::ST_OK, 0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_FIRE, 0, 0, 0, 1, stq_pkg::ST_EMPTY,
                                     0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'h0F0F_0F0F, 0, stq_pkg::ST_OK, 0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_NOP, 0, 0, 0, 0, stq_pkg::ST_OK,
                                     0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                                     stq_pkg::ST_OK, 0, 0, 0, 0, 0));
        stim_list.push_back(stim_row(stq_pkg::CMD_FIRE, 0, 0, 0, 0, stq_pkg::ST_OK,
                                     0, 0, 0, 0, 0));

        foreach (stim_list[i])
            offer(stim_list[i]);

        run_random(230, 45, 25, 25);

        // hold the command side until the queue of results has drained
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);

        // fill to the brim while the result side holds off for a long stretch
        hold_request = 1'b1;
        run_random(200, 85, 5, 10);
        gaps_on = 1'b0;
        run_random(150, 30, 60, 10);
        gaps_on = 1'b1;
        run_random(150, 10, 15, 75);
        gaps_on = 1'b0;
        run_random(100, 40, 25, 30);

        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
